/* sv/pscp_pkg.sv */
package pscp_pkg;

  localparam int OUT_W     = 26;
  localparam int ROOT_W    = 26;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int THR_W     = 23;
  localparam int A_IM      = 56756;
  localparam int THIRD_NUM = 21845;

  // configuration register indexes
  localparam logic [0:0] REG_SELECT    = 1'd0;
  localparam logic [0:0] REG_THRESHOLD = 1'd1;

  typedef enum logic [2:0] {
    SEL_A       = 3'd0,
    SEL_B       = 3'd1,
    SEL_C       = 3'd2,
    SEL_NEUTRAL = 3'd3,
    SEL_ZERO    = 3'd4,
    SEL_POS     = 3'd5,
    SEL_NEG     = 3'd6,
    SEL_NONE    = 3'd7
  } sel_t;

  // one beat travelling down the square root chain
  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    seq;
    logic [RAD_W-1:0]        rem;
    logic [RAD_W-1:0]        root;
  } root_t;

endpackage

/* sv/pscp_if.sv */
interface pscp_in_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] phase_a_real;
  logic signed [SAMPLE_WIDTH-1:0] phase_a_imag;
  logic signed [SAMPLE_WIDTH-1:0] phase_b_real;
  logic signed [SAMPLE_WIDTH-1:0] phase_b_imag;
  logic signed [SAMPLE_WIDTH-1:0] phase_c_real;
  logic signed [SAMPLE_WIDTH-1:0] phase_c_imag;

  modport source (
    output valid, phase_a_real, phase_a_imag, phase_b_real, phase_b_imag,
           phase_c_real, phase_c_imag,
    input  ready
  );
  modport sink (
    input  valid, phase_a_real, phase_a_imag, phase_b_real, phase_b_imag,
           phase_c_real, phase_c_imag,
    output ready
  );
endinterface

interface pscp_out_if import pscp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] result_real;
  logic signed [OUT_W-1:0] result_imag;
  logic [OUT_W-1:0]        result_magnitude;
  logic                    phasor_enabled;

  modport source (
    output valid, result_real, result_imag, result_magnitude, phasor_enabled,
    input  ready
  );
  modport sink (
    input  valid, result_real, result_imag, result_magnitude, phasor_enabled,
    output ready
  );
endinterface

/* sv/pscp_front.sv */
module pscp_front import pscp_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  sel_t         sel,
  pscp_in_if.sink      in_ch,
  output logic         out_valid,
  input  logic         out_ready,
  output root_t        out_data
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int PW     = SW + 17;
  localparam int SSW    = SW + 18;
  localparam int MW     = SW + 17;
  localparam int HPW    = SW + 16;
  localparam int STAGES = 7;

  localparam logic signed [17:0] A_IM_S  = 18'(A_IM);
  localparam logic [14:0]        THIRD_C = 15'(THIRD_NUM);
  localparam logic signed [MW:0] SAT_HI  = (MW+1)'(2**(OUT_W-1) - 1);
  localparam logic signed [MW:0] SAT_LO  = (MW+1)'(-(2**(OUT_W-1)));

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] rdy;

  // stage 1: samples and the a-weighted products
  logic signed [SW-1:0] ar_r, ai_r, br_r, bi_r, cr_r, ci_r;
  logic signed [PW-1:0] pbr_r, pbi_r, pcr_r, pci_r;
  // stage 2: selected value, q.16 sum in sequence modes
  logic signed [SSW-1:0] vre_r, vim_r, vre_nxt, vim_nxt;
  logic                  seq2_r, seq2_nxt;
  // stage 3: magnitude and sign
  logic [MW-1:0] mre_r, mim_r;
  logic          nre_r, nim_r, seq3_r;
  // stage 4: one-third partial products
  logic [HPW-1:0] hre_r, him_r;
  logic [14:0]    lre_r, lim_r;
  logic [MW-1:0]  mre4_r, mim4_r;
  logic           nre4_r, nim4_r, seq4_r;
  // stage 5: signed, saturated part
  logic signed [OUT_W-1:0] re5_r, im5_r, re5_nxt, im5_nxt;
  logic                    seq5_r;
  // stage 6: squares
  logic signed [RAD_W-1:0] sqre_r, sqim_r;
  logic signed [OUT_W-1:0] re6_r, im6_r;
  logic                    seq6_r;
  // stage 7
  root_t out_r;

  always_comb begin
    rdy[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_ch.ready = rdy[0];
  assign out_valid   = v_r[STAGES-1];
  assign out_data    = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // stage 2 selection
  logic signed [SSW-1:0] a16, ai16, b15, bi15, c15, ci15;
  logic signed [SSW-1:0] ebr, ebi, ecr, eci;
  logic signed [SSW-1:0] sum_re, sum_im;

  always_comb begin
    a16  = SSW'(ar_r) <<< 16;
    ai16 = SSW'(ai_r) <<< 16;
    b15  = SSW'(br_r) <<< 15;
    bi15 = SSW'(bi_r) <<< 15;
    c15  = SSW'(cr_r) <<< 15;
    ci15 = SSW'(ci_r) <<< 15;
    ebr  = SSW'(pbr_r);
    ebi  = SSW'(pbi_r);
    ecr  = SSW'(pcr_r);
    eci  = SSW'(pci_r);
    sum_re = SSW'(ar_r) + SSW'(br_r) + SSW'(cr_r);
    sum_im = SSW'(ai_r) + SSW'(bi_r) + SSW'(ci_r);
    vre_nxt  = '0;
    vim_nxt  = '0;
    seq2_nxt = 1'b0;
    case (sel)
      SEL_A: begin
        vre_nxt = SSW'(ar_r);
        vim_nxt = SSW'(ai_r);
      end
      SEL_B: begin
        vre_nxt = SSW'(br_r);
        vim_nxt = SSW'(bi_r);
      end
      SEL_C: begin
        vre_nxt = SSW'(cr_r);
        vim_nxt = SSW'(ci_r);
      end
      SEL_NEUTRAL: begin
        vre_nxt = sum_re;
        vim_nxt = sum_im;
      end
      SEL_ZERO: begin
        vre_nxt  = sum_re <<< 16;
        vim_nxt  = sum_im <<< 16;
        seq2_nxt = 1'b1;
      end
      SEL_POS: begin
        vre_nxt  = a16 - b15 - ebi - c15 + eci;
        vim_nxt  = ai16 - bi15 + ebr - ci15 - ecr;
        seq2_nxt = 1'b1;
      end
      SEL_NEG: begin
        vre_nxt  = a16 - b15 + ebi - c15 - eci;
        vim_nxt  = ai16 - bi15 - ebr - ci15 + ecr;
        seq2_nxt = 1'b1;
      end
      default: begin
        vre_nxt  = '0;
        vim_nxt  = '0;
        seq2_nxt = 1'b0;
      end
    endcase
  end

  // stage 4 products
  logic [30:0] lre_full, lim_full;
  assign lre_full = 31'(mre_r[15:0]) * 31'(THIRD_C);
  assign lim_full = 31'(mim_r[15:0]) * 31'(THIRD_C);

  // stage 5: sum partials in sequence modes, restore sign, clamp
  logic [HPW:0]        tre, tim;
  logic [MW-1:0]       qre, qim;
  logic signed [MW:0]  sre, sim;

  always_comb begin
    tre = (HPW+1)'(hre_r) + (HPW+1)'(lre_r);
    tim = (HPW+1)'(him_r) + (HPW+1)'(lim_r);
    qre = seq4_r ? MW'(tre[HPW:16]) : mre4_r;
    qim = seq4_r ? MW'(tim[HPW:16]) : mim4_r;
    sre = nre4_r ? -$signed({1'b0, qre}) : $signed({1'b0, qre});
    sim = nim4_r ? -$signed({1'b0, qim}) : $signed({1'b0, qim});
    if (sre > SAT_HI) begin
      re5_nxt = OUT_W'(SAT_HI);
    end else if (sre < SAT_LO) begin
      re5_nxt = OUT_W'(SAT_LO);
    end else begin
      re5_nxt = OUT_W'(sre);
    end
    if (sim > SAT_HI) begin
      im5_nxt = OUT_W'(SAT_HI);
    end else if (sim < SAT_LO) begin
      im5_nxt = OUT_W'(SAT_LO);
    end else begin
      im5_nxt = OUT_W'(sim);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ar_r  <= in_ch.phase_a_real;
      ai_r  <= in_ch.phase_a_imag;
      br_r  <= in_ch.phase_b_real;
      bi_r  <= in_ch.phase_b_imag;
      cr_r  <= in_ch.phase_c_real;
      ci_r  <= in_ch.phase_c_imag;
      pbr_r <= PW'(A_IM_S) * PW'(in_ch.phase_b_real);
      pbi_r <= PW'(A_IM_S) * PW'(in_ch.phase_b_imag);
      pcr_r <= PW'(A_IM_S) * PW'(in_ch.phase_c_real);
      pci_r <= PW'(A_IM_S) * PW'(in_ch.phase_c_imag);
    end
    if (rdy[1]) begin
      vre_r  <= vre_nxt;
      vim_r  <= vim_nxt;
      seq2_r <= seq2_nxt;
    end
    if (rdy[2]) begin
      nre_r  <= vre_r[SSW-1];
      nim_r  <= vim_r[SSW-1];
      mre_r  <= MW'(vre_r[SSW-1] ? -vre_r : vre_r);
      mim_r  <= MW'(vim_r[SSW-1] ? -vim_r : vim_r);
      seq3_r <= seq2_r;
    end
    if (rdy[3]) begin
      hre_r  <= HPW'(mre_r[MW-1:16]) * HPW'(THIRD_C);
      him_r  <= HPW'(mim_r[MW-1:16]) * HPW'(THIRD_C);
      lre_r  <= lre_full[30:16];
      lim_r  <= lim_full[30:16];
      mre4_r <= mre_r;
      mim4_r <= mim_r;
      nre4_r <= nre_r;
      nim4_r <= nim_r;
      seq4_r <= seq3_r;
    end
    if (rdy[4]) begin
      re5_r  <= re5_nxt;
      im5_r  <= im5_nxt;
      seq5_r <= seq4_r;
    end
    if (rdy[5]) begin
      sqre_r <= RAD_W'(re5_r) * RAD_W'(re5_r);
      sqim_r <= RAD_W'(im5_r) * RAD_W'(im5_r);
      re6_r  <= re5_r;
      im6_r  <= im5_r;
      seq6_r <= seq5_r;
    end
    if (rdy[6]) begin
      out_r.re   <= re6_r;
      out_r.im   <= im6_r;
      out_r.seq  <= seq6_r;
      out_r.rem  <= $unsigned(sqre_r) + $unsigned(sqim_r);
      out_r.root <= '0;
    end
  end

endmodule

/* sv/pscp_root_cell.sv */
module pscp_root_cell import pscp_pkg::*; #(
  parameter int BIT_POS = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  root_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output root_t out_data
);

  localparam logic [RAD_W-1:0] ONE_BIT = RAD_W'(1) << (2 * BIT_POS);

  logic  valid_r;
  root_t data_r, data_nxt;
  logic [RAD_W:0] trial;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // one restoring step of the digit-by-digit root
  always_comb begin
    data_nxt = in_data;
    trial    = {1'b0, in_data.root} + {1'b0, ONE_BIT};
    if ({1'b0, in_data.rem} >= trial) begin
      data_nxt.rem  = in_data.rem - trial[RAD_W-1:0];
      data_nxt.root = (in_data.root >> 1) + ONE_BIT;
    end else begin
      data_nxt.root = in_data.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* sv/phase_and_sequence_current_phasor_unit.sv */
// pipeline: a beat passes through 7 arithmetic stages, 26 square root
// cells and 1 output register
// throughput: one beat per cycle unless the output stalls; every stage
// moves on its own, so bubbles close up and up to 34 beats are in flight
// while the output is stalled; reset: synchronous, clears all valid bits;
// quantity select goes to none, zero threshold to 1
module phase_and_sequence_current_phasor_unit import pscp_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [THR_W-1:0] cfg_wdata,
  pscp_in_if.sink          in_ch,
  pscp_out_if.source       out_ch
);

  localparam logic [OUT_W-1:0] MAG_BOUND     = 26'd47453132;

  sel_t             sel_r;
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= SEL_NONE;
      thr_r <= THR_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SELECT:    sel_r <= sel_t'(cfg_wdata[2:0]);
        REG_THRESHOLD: thr_r <= cfg_wdata;
        default:       thr_r <= thr_r;
      endcase
    end
  end

  logic [ROOT_W:0] cell_v;
  logic [ROOT_W:0] cell_rdy;
  root_t           cell_d [ROOT_W+1];

  pscp_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .sel       (sel_r),
    .in_ch     (in_ch),
    .out_valid (cell_v[0]),
    .out_ready (cell_rdy[0]),
    .out_data  (cell_d[0])
  );

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    pscp_root_cell #(.BIT_POS(ROOT_W - 1 - i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cell_v[i]),
      .in_ready  (cell_rdy[i]),
      .in_data   (cell_d[i]),
      .out_valid (cell_v[i+1]),
      .out_ready (cell_rdy[i+1]),
      .out_data  (cell_d[i+1])
    );
  end

  // output register with the sequence threshold
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] re_r, im_r;
  logic [OUT_W-1:0]        mag_r;
  logic                    en_r;
  logic [OUT_W-1:0]        mag;
  logic                    kill;

  assign mag              = cell_d[ROOT_W].root[OUT_W-1:0];
  assign kill             = cell_d[ROOT_W].seq && (mag <= OUT_W'(thr_r));
  assign cell_rdy[ROOT_W] = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cell_rdy[ROOT_W]) begin
      out_valid_r <= cell_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cell_rdy[ROOT_W]) begin
      re_r  <= kill ? '0 : cell_d[ROOT_W].re;
      im_r  <= kill ? '0 : cell_d[ROOT_W].im;
      mag_r <= kill ? '0 : mag;
      en_r  <= !kill && (mag != '0);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_real      = re_r;
  assign out_ch.result_imag      = im_r;
  assign out_ch.result_magnitude = mag_r;
  assign out_ch.phasor_enabled   = en_r;

  // input only stalls when the whole chain is full behind a stalled output
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready && (&cell_v)))
    else $error("input stalled with room in the pipeline");

  // nothing appears at the output unless the last cell held a beat
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_ch.valid && !cell_v[ROOT_W]) |=> !out_ch.valid)
    else $error("result beat without a source");

  // saturated parts bound the root
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.result_magnitude <= MAG_BOUND))
    else $error("magnitude beyond its bound");

endmodule
